// File: rtl/core/fahc_pkg.sv
`timescale 1ns / 1ps

package fahc_pkg;

   localparam int VEL_W     = 16;                  // Q4.12 velocity
   localparam int MSTEP_W   = 15;                  // Q3.12 allowed rise
   localparam int WEIGHT_W  = 16;                  // Q8.8 weight
   localparam int POWER_W   = 3;
   localparam int COST_W    = 32;                  // Q16.16 cost
   localparam int PROD_W    = 2 * COST_W;          // shared multiplier output
   localparam int NUM_W     = COST_W + WEIGHT_W;   // sum times weight
   localparam int DEN_SHIFT = 4;                   // divide by steps * 16
   localparam int QUO_W     = NUM_W - DEN_SHIFT;
   localparam int FRAC_W    = 16;                  // Q16.16 rescale after multiply

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_LIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER    = 2'd3;

   localparam logic                RST_ENABLE   = 1'b1;
   localparam logic [MSTEP_W-1:0]  RST_RISE_LIM = 15'd102;
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT   = 16'd1280;
   localparam logic [POWER_W-1:0]  RST_POWER    = 3'd1;

   localparam logic [COST_W-1:0] COST_MAX = '1;

endpackage

// File: rtl/core/fahc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module fahc_div #(
   parameter int DEN_W = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [fahc_pkg::QUO_W-1:0] dividend,
   input  logic [DEN_W-1:0]         divisor,
   output logic                     done,
   output logic [fahc_pkg::QUO_W-1:0] quotient
);

   localparam int CNT_W = $clog2(fahc_pkg::QUO_W + 1);

   logic [fahc_pkg::QUO_W-1:0] dvd_ff, dvd_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [DEN_W:0]             rem_shift;
   logic [DEN_W:0]             rem_diff;
   logic                       fits;

   assign rem_shift = {rem_ff, dvd_ff[fahc_pkg::QUO_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor};
   assign fits      = (rem_shift >= {1'b0, divisor});

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(fahc_pkg::QUO_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         // remainder stays below the divisor, so it fits DEN_W bits
         rem_in = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         dvd_in = {dvd_ff[fahc_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// File: rtl/core/forward_accel_hinge_cost_unit.sv
`timescale 1ns / 1ps

// Forward acceleration hinge cost.
// req channel: one velocity sample per transaction; req_last marks the final
// sample of a trajectory and req_prior_cost is read only with it.
// rsp channel: one rsp_total_cost transaction per trajectory, after its last
// sample. csr port: plain writes of enable, rise limit, weight and power.
// A non-last sample is absorbed without starting a sequence. A last sample with the penalty
// enabled and at least one step runs a sequence on one shared 32x32
// multiplier and a bit-serial divider: one multiply by the weight, a divider
// start, the bit-serial divide of the 44-bit quotient by the step count, taking
// the quotient, power-1 further multiplies (0 to 6), then an add of prior_cost
// that loads the output register once it is free. req_stall is high during that
// sequence. A disabled or single-sample trajectory loads prior_cost straight
// into the output register.
// While a result waits under rsp_stall, req_stall is held high as well.
// Reset (synchronous) returns the registers to their defaults, clears the
// running sum and step count and drops rsp_valid.
module forward_accel_hinge_cost_unit #(
   parameter int MAX_STEPS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fahc_pkg::VEL_W-1:0]   req_velocity,
   input  logic                                req_last,
   input  logic [fahc_pkg::COST_W-1:0]         req_prior_cost,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fahc_pkg::COST_W-1:0]         rsp_total_cost,
   input  logic                                csr_write_en,
   input  logic [fahc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fahc_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int STEP_W = $clog2(MAX_STEPS);
   localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_STEPS - 1);
   localparam int VW = fahc_pkg::VEL_W;
   localparam int CW = fahc_pkg::COST_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIV_GO,
      S_DIV_WAIT,
      S_POW,
      S_DONE
   } state_type;

   // configuration
   logic                              en_ff;
   logic [fahc_pkg::MSTEP_W-1:0]      rise_lim_ff;
   logic [fahc_pkg::WEIGHT_W-1:0]     weight_ff;
   logic [fahc_pkg::POWER_W-1:0]      power_ff;

   // trajectory accumulation
   logic [VW-1:0]                     prev_ff;
   logic [CW-1:0]                     sum_ff;
   logic [STEP_W-1:0]                 step_ff;
   logic                              first_ff;

   // sequencer and datapath
   state_type                         state_ff, state_in;
   logic [CW-1:0]                     work_sum_ff;
   logic [STEP_W-1:0]                 div_ff;
   logic [CW-1:0]                     prior_ff;
   logic [fahc_pkg::NUM_W-1:0]        num_ff;
   logic [CW-1:0]                     base_ff;
   logic [CW-1:0]                     res_ff, res_in;
   logic [fahc_pkg::POWER_W-1:0]      pow_left_ff;
   logic                              rsp_valid_ff;
   logic [CW-1:0]                     rsp_cost_ff;

   logic                              accept;
   logic                              out_free;
   logic [VW:0]                       dv;
   logic [VW-1:0]                     rise;
   logic [VW-1:0]                     excess;
   logic [CW:0]                       sum_wide;
   logic [CW-1:0]                     sum_next;
   logic                              counting;
   logic [STEP_W-1:0]                 step_next;
   logic [CW-1:0]                     mul_a, mul_b;
   logic [fahc_pkg::PROD_W-1:0]       prod;
   logic [CW-1:0]                     prod_sat;
   logic                              div_start, div_done;
   logic [fahc_pkg::QUO_W-1:0]        quo;
   logic [CW-1:0]                     quo_sat;
   logic [CW:0]                       total_wide;
   logic [CW-1:0]                     total_sat;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   // per-step hinge on the velocity rise
   assign dv       = {req_velocity[VW-1], req_velocity} - {prev_ff[VW-1], prev_ff};
   assign rise     = dv[VW] ? '0 : dv[VW-1:0];
   assign excess   = (rise > {1'b0, rise_lim_ff}) ? (rise - {1'b0, rise_lim_ff}) : '0;
   assign sum_wide = {1'b0, sum_ff} + {{(CW + 1 - VW){1'b0}}, excess};
   assign counting = !first_ff && (step_ff < STEP_LIMIT);
   assign sum_next  = !counting ? sum_ff : (sum_wide[CW] ? fahc_pkg::COST_MAX : sum_wide[CW-1:0]);
   assign step_next = counting ? step_ff + 1'b1 : step_ff;

   // shared multiplier: sum * weight first, then the power steps
   assign mul_a    = (state_ff == S_MUL) ? work_sum_ff : res_ff;
   assign mul_b    = (state_ff == S_MUL) ? {{(CW - fahc_pkg::WEIGHT_W){1'b0}}, weight_ff}
                                         : base_ff;
   assign prod     = {{CW{1'b0}}, mul_a} * {{CW{1'b0}}, mul_b};
   assign prod_sat = (prod[fahc_pkg::PROD_W-1:CW + fahc_pkg::FRAC_W] != '0)
                     ? fahc_pkg::COST_MAX : prod[CW + fahc_pkg::FRAC_W - 1:fahc_pkg::FRAC_W];

   assign div_start = (state_ff == S_DIV_GO);
   assign quo_sat   = (quo[fahc_pkg::QUO_W-1:CW] != '0) ? fahc_pkg::COST_MAX : quo[CW-1:0];

   assign total_wide = {1'b0, prior_ff} + {1'b0, res_ff};
   assign total_sat  = total_wide[CW] ? fahc_pkg::COST_MAX : total_wide[CW-1:0];

   fahc_div #(
      .DEN_W(STEP_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff[fahc_pkg::NUM_W-1:fahc_pkg::DEN_SHIFT]),
      .divisor  (div_ff),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_last && en_ff && (step_next != '0)) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               res_in   = quo_sat;
               state_in = (power_ff > 3'd1) ? S_POW : S_DONE;
            end
         end
         S_POW: begin
            res_in = prod_sat;
            if (pow_left_ff == 3'd1) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (accept && req_last) begin
         work_sum_ff <= sum_next;
         div_ff      <= step_next;
         prior_ff    <= req_prior_cost;
      end
      if (state_ff == S_MUL) begin
         num_ff <= prod[fahc_pkg::NUM_W-1:0];
      end
      if (state_ff == S_DIV_WAIT && div_done) begin
         base_ff     <= quo_sat;
         pow_left_ff <= power_ff - 1'b1;
      end else if (state_ff == S_POW) begin
         pow_left_ff <= pow_left_ff - 1'b1;
      end

      if (reset) begin
         state_ff     <= S_IDLE;
         en_ff        <= fahc_pkg::RST_ENABLE;
         rise_lim_ff  <= fahc_pkg::RST_RISE_LIM;
         weight_ff    <= fahc_pkg::RST_WEIGHT;
         power_ff     <= fahc_pkg::RST_POWER;
         prev_ff      <= '0;
         sum_ff       <= '0;
         step_ff      <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_write_en) begin
            case (csr_index)
               fahc_pkg::CSR_ENABLE:   en_ff       <= csr_data[0];
               fahc_pkg::CSR_RISE_LIM: rise_lim_ff <= csr_data[fahc_pkg::MSTEP_W-1:0];
               fahc_pkg::CSR_WEIGHT:   weight_ff   <= csr_data;
               fahc_pkg::CSR_POWER:    power_ff    <= csr_data[fahc_pkg::POWER_W-1:0];
               default: begin
               end
            endcase
         end

         if (accept) begin
            prev_ff <= req_velocity;
            if (req_last) begin
               sum_ff   <= '0;
               step_ff  <= '0;
               first_ff <= 1'b1;
            end else begin
               sum_ff   <= sum_next;
               step_ff  <= step_next;
               first_ff <= 1'b0;
            end
         end

         // pass-through when disabled or no steps were taken
         if (accept && req_last && !(en_ff && (step_next != '0))) begin
            rsp_valid_ff <= 1'b1;
            rsp_cost_ff  <= req_prior_cost;
         end else if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_cost_ff  <= total_sat;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_total_cost = rsp_cost_ff;

endmodule

// File: test/tb_forward_accel_hinge_cost_unit.sv
`timescale 1ns / 1ps

module tb_forward_accel_hinge_cost_unit;

   localparam int MAX_STEPS  = 256;
   localparam int SETTLE     = 64;     // covers the longest last-sample sequence
   localparam int QUIET_MAX  = 5000;
   localparam int HOLD_LONG  = 400;
   localparam int PHASE_LEN  = 120;
   localparam int NUM_PHASES = 6;

   typedef logic signed [fahc_pkg::VEL_W-1:0] vel_type;
   typedef logic [fahc_pkg::COST_W-1:0]       cost_type;
   typedef enum bit {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                    kind;
      logic [fahc_pkg::CSR_IDX_W-1:0]  idx;
      logic [fahc_pkg::CSR_DATA_W-1:0] data;
      vel_type                         vel;
      logic                            fin;
      cost_type                        prior;
      bit                              fixed;
      cost_type                        want;
   } dir_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   vel_type                         req_velocity = '0;
   logic                            req_last = 1'b0;
   cost_type                        req_prior_cost = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   cost_type                        rsp_total_cost;
   logic                            csr_write_en = 1'b0;
   logic [fahc_pkg::CSR_IDX_W-1:0]  csr_index = fahc_pkg::CSR_ENABLE;
   logic [fahc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // shadow of the unit's registers and running state
   logic                          cfg_on    = fahc_pkg::RST_ENABLE;
   logic [fahc_pkg::MSTEP_W-1:0]  cfg_mstep = fahc_pkg::RST_RISE_LIM;
   logic [fahc_pkg::WEIGHT_W-1:0] cfg_wt    = fahc_pkg::RST_WEIGHT;
   logic [fahc_pkg::POWER_W-1:0]  cfg_pw    = fahc_pkg::RST_POWER;
   vel_type                       last_vel  = '0;
   cost_type                      rise_sum  = '0;
   int unsigned                   n_steps   = 0;
   bit                            at_start  = 1'b1;

   cost_type total_due_q[$];
   int       errors = 0;
   int       items_sent = 0;
   int       tx_idle_pct = 0;
   int       rx_stall_pct = 0;
   int       hold_req = 0;
   int       quiet = 0;

   forward_accel_hinge_cost_unit #(
      .MAX_STEPS(MAX_STEPS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_velocity  (req_velocity),
      .req_last      (req_last),
      .req_prior_cost(req_prior_cost),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_total_cost(rsp_total_cost),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic dir_row_type smp(vel_type v, logic fin, cost_type prior);
      return '{ROW_SAMPLE, fahc_pkg::CSR_ENABLE, '0, v, fin, prior, 1'b0, '0};
   endfunction

   function automatic dir_row_type smp_fix(vel_type v, cost_type prior, cost_type want);
      return '{ROW_SAMPLE, fahc_pkg::CSR_ENABLE, '0, v, 1'b1, prior, 1'b1, want};
   endfunction

   function automatic dir_row_type reg_row(logic [fahc_pkg::CSR_IDX_W-1:0] idx,
                                           logic [fahc_pkg::CSR_DATA_W-1:0] data);
      return '{ROW_CSR, idx, data, '0, 1'b0, '0, 1'b0, '0};
   endfunction

   dir_row_type dir_rows [35] = '{
      smp_fix(16'h0000, 32'h0000_0000, 32'h0000_0000),
      smp_fix(16'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      smp(16'h8000, 1'b0, 32'h0),
      smp(16'h7FFF, 1'b1, 32'h0),
      // deceleration only
      smp(16'h7FFF, 1'b0, 32'h0),
      smp_fix(16'h8000, 32'h1234_5678, 32'h1234_5678),
      // rise exactly at the limit
      smp(16'h0000, 1'b0, 32'h0),
      smp_fix(16'h0066, 32'h0000_0005, 32'h0000_0005),
      // one LSB over the limit: 1 * 1280 / 16
      smp(16'h0000, 1'b0, 32'h0),
      smp_fix(16'h0067, 32'h0000_0000, 32'd80),
      smp(16'h8000, 1'b0, 32'h0),
      smp_fix(16'h7FFF, 32'hFFFF_FF00, 32'hFFFF_FFFF),
      reg_row(fahc_pkg::CSR_ENABLE, 16'd0),
      smp(16'h8000, 1'b0, 32'h0),
      smp_fix(16'h7FFF, 32'h0000_ABCD, 32'h0000_ABCD),
      reg_row(fahc_pkg::CSR_ENABLE, 16'd1),
      reg_row(fahc_pkg::CSR_POWER, 16'd0),
      smp(16'h0000, 1'b0, 32'h0),
      smp(16'h1066, 1'b0, 32'h0),
      smp(16'h2066, 1'b1, 32'h0),
      reg_row(fahc_pkg::CSR_POWER, 16'd7),
      smp(16'h0000, 1'b0, 32'h0),
      smp(16'h4000, 1'b1, 32'h0000_0100),
      reg_row(fahc_pkg::CSR_POWER, 16'd2),
      reg_row(fahc_pkg::CSR_RISE_LIM, 16'd0),
      reg_row(fahc_pkg::CSR_WEIGHT, 16'hFFFF),
      smp(16'h8000, 1'b0, 32'h0),
      smp(16'h7FFF, 1'b1, 32'h0),
      reg_row(fahc_pkg::CSR_RISE_LIM, 16'h7FFF),
      reg_row(fahc_pkg::CSR_WEIGHT, 16'd0),
      smp(16'h8000, 1'b0, 32'h0),
      smp_fix(16'h7FFF, 32'h0000_0007, 32'h0000_0007),
      reg_row(fahc_pkg::CSR_WEIGHT, 16'(fahc_pkg::RST_WEIGHT)),
      reg_row(fahc_pkg::CSR_RISE_LIM, 16'(fahc_pkg::RST_RISE_LIM)),
      reg_row(fahc_pkg::CSR_POWER, 16'(fahc_pkg::RST_POWER))
   };

   // mean excess times weight, then the integer power
   function automatic cost_type hinge_penalty();
      logic [63:0] num, den, base, acc;
      num  = 64'(rise_sum) * 64'(cfg_wt);
      den  = 64'(n_steps) * 64'd16;
      base = num / den;
      if (base > 64'(fahc_pkg::COST_MAX)) base = 64'(fahc_pkg::COST_MAX);
      acc = base;
      for (int i = 1; i < int'(cfg_pw); i++) begin
         acc = (acc * base) >> fahc_pkg::FRAC_W;
         if (acc > 64'(fahc_pkg::COST_MAX)) acc = 64'(fahc_pkg::COST_MAX);
      end
      return acc[fahc_pkg::COST_W-1:0];
   endfunction

   task automatic track_sample(input vel_type v, input logic fin, input cost_type prior,
                               input bit fixed, input cost_type want);
      int           rise;
      int           excess;
      logic [32:0]  sum;
      cost_type     total;
      if (at_start) begin
         at_start = 1'b0;
      end else if (n_steps < MAX_STEPS - 1) begin
         rise   = int'(v) - int'(last_vel);
         excess = (rise > 0 ? rise : 0) - int'(cfg_mstep);
         if (excess > 0) begin
            sum      = {1'b0, rise_sum} + 33'(excess);
            rise_sum = sum[32] ? fahc_pkg::COST_MAX : sum[31:0];
         end
         n_steps++;
      end
      last_vel = v;
      if (fin) begin
         if (cfg_on && n_steps != 0) begin
            sum   = {1'b0, prior} + {1'b0, hinge_penalty()};
            total = sum[32] ? fahc_pkg::COST_MAX : sum[31:0];
         end else begin
            total = prior;
         end
         total_due_q.push_back(fixed ? want : total);
         rise_sum = '0;
         n_steps  = 0;
         at_start = 1'b1;
      end
   endtask

   // called after a posedge; returns at the posedge of acceptance
   task automatic push_sample(input vel_type v, input logic fin, input cost_type prior,
                              input bit fixed, input cost_type want);
      @(negedge clock);
      while ($urandom_range(1, 100) <= tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_velocity   <= v;
      req_last       <= fin;
      req_prior_cost <= prior;
      do @(posedge clock); while (req_stall);
      items_sent++;
      track_sample(v, fin, prior, fixed, want);
   endtask

   // drop valid, wait for all results, then let a last-sample sequence finish
   task automatic wait_idle(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (total_due_q.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic put_reg(input logic [fahc_pkg::CSR_IDX_W-1:0] idx,
                          input logic [fahc_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      case (idx)
         fahc_pkg::CSR_ENABLE:   cfg_on    = data[0];
         fahc_pkg::CSR_RISE_LIM: cfg_mstep = data[fahc_pkg::MSTEP_W-1:0];
         fahc_pkg::CSR_WEIGHT:   cfg_wt    = data[fahc_pkg::WEIGHT_W-1:0];
         fahc_pkg::CSR_POWER:    cfg_pw    = data[fahc_pkg::POWER_W-1:0];
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [fahc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fahc_pkg::CSR_DATA_W-1:0] data);
      wait_idle(SETTLE);
      put_reg(idx, data);
      csr_write_en <= 1'b0;
   endtask

   task automatic apply_config(input int en, input int mstep, input int wt, input int pw);
      wait_idle(SETTLE);
      put_reg(fahc_pkg::CSR_ENABLE, 16'(en));
      put_reg(fahc_pkg::CSR_RISE_LIM, 16'(mstep));
      put_reg(fahc_pkg::CSR_WEIGHT, 16'(wt));
      put_reg(fahc_pkg::CSR_POWER, 16'(pw));
      csr_write_en <= 1'b0;
   endtask

   // mostly rises around the limit, with decelerations and arbitrary jumps
   task automatic send_trajectory(input int len, input bit close);
      int       v;
      cost_type prior;
      v = int'($urandom_range(0, 65535)) - 32768;
      for (int i = 0; i < len; i++) begin
         if (i > 0) begin
            case ($urandom_range(0, 9))
               0, 1:    v = int'($urandom_range(0, 65535)) - 32768;
               2, 3:    v = v - int'($urandom_range(0, 4000));
               default: v = v + int'(cfg_mstep) + int'($urandom_range(0, 400)) - 200;
            endcase
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
         end
         case ($urandom_range(0, 5))
            0:       prior = '0;
            1:       prior = fahc_pkg::COST_MAX - cost_type'($urandom_range(0, 1000));
            default: prior = cost_type'($urandom);
         endcase
         push_sample(vel_type'(v), close && (i == len - 1), prior, 1'b0, '0);
      end
   endtask

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 6);
      if (r < 98) return $urandom_range(7, 40);
      return $urandom_range(240, 300);
   endfunction

   always @(negedge clock) begin
      if (hold_req > 0) begin
         rsp_stall <= 1'b1;
         hold_req = hold_req - 1;
      end else begin
         rsp_stall <= ($urandom_range(1, 100) <= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (total_due_q.size() == 0) begin
            $error("total_cost: no transaction expected, actual %h", rsp_total_cost);
            errors++;
         end else begin
            if (rsp_total_cost !== total_due_q[0]) begin
               $error("total_cost mismatch: expected %h, actual %h",
                      total_due_q[0], rsp_total_cost);
               errors++;
            end
            void'(total_due_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_MAX) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int target;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            write_reg(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            push_sample(dir_rows[i].vel, dir_rows[i].fin, dir_rows[i].prior,
                        dir_rows[i].fixed, dir_rows[i].want);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // after the first phase, a partial trajectory from the previous phase spans this config change
         case (phase)
            0: apply_config(1, fahc_pkg::RST_RISE_LIM, fahc_pkg::RST_WEIGHT,
                            fahc_pkg::RST_POWER);
            1: apply_config(1, 0, 16'hFFFF, 2);
            2: apply_config(1, 16'h7FFF, 0, 0);
            3: apply_config(0, $urandom_range(0, 32767), $urandom_range(0, 65535),
                            $urandom_range(0, 7));
            4: apply_config(1, $urandom_range(0, 400), $urandom_range(0, 65535),
                            $urandom_range(3, 4));
            default: apply_config(1, $urandom_range(0, 400), $urandom_range(0, 2048),
                                  $urandom_range(0, 7));
         endcase
         @(posedge clock);
         case (phase % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
            default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
         endcase
         // receiver holds off while the sender keeps offering transactions
         if (phase == 2) hold_req = HOLD_LONG;
         target = items_sent + PHASE_LEN;
         if (phase == 0) send_trajectory(MAX_STEPS + 4, 1'b1);
         while (items_sent < target) begin
            if ($urandom_range(0, 39) == 0) wait_idle(0);
            send_trajectory(pick_len(), 1'b1);
         end
         if (phase < NUM_PHASES - 1) send_trajectory($urandom_range(1, 3), 1'b0);
      end

      wait_idle(SETTLE);
      if (errors == 0 && total_due_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/fahc_pkg.sv
rtl/core/fahc_div.sv
rtl/core/forward_accel_hinge_cost_unit.sv
test/tb_forward_accel_hinge_cost_unit.sv
